/* rtl/amr_pkg.sv */
package amr_pkg;

    // default table depth
    localparam int DEF_MAX_OBSTACLES = 8;

    // internal coordinate width, wide enough for repeated back-offs and snaps
    localparam int POS_W = 32;

    // field widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int SPEED_W = 11;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MOVE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST_COUNT  = 2'd2;

    // configuration reset values
    localparam logic [SIZE_W-1:0]  RST_AREA_WIDTH  = 15'd256;
    localparam logic [SIZE_W-1:0]  RST_AREA_HEIGHT = 15'd256;
    localparam logic [COUNT_W-1:0] RST_OBST_COUNT  = 4'd0;

    typedef logic signed [POS_W-1:0] pos_t;

    // one stored obstacle rectangle
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } rect_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_FIX,
        ST_CLAMP,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic wr;
        logic test;
        logic fix;
        logic advance;
        logic clamp;
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic overlap;
        logic last;
        logic empty;
    } stat_t;

    function automatic pos_t sx_coord(input logic signed [COORD_W-1:0] v);
        return {{(POS_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic pos_t zx_size(input logic [SIZE_W-1:0] v);
        return {{(POS_W-SIZE_W){1'b0}}, v};
    endfunction

    function automatic pos_t sx_speed(input logic signed [SPEED_W-1:0] v);
        return {{(POS_W-SPEED_W){v[SPEED_W-1]}}, v};
    endfunction

endpackage

/* rtl/amr_ctrl.sv */
module amr_ctrl
    import amr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  command,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy,
    output logic  done
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && command == CMD_MOVE)
                begin
                    state_next = stat.empty ? ST_CLAMP : ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (stat.overlap)
                begin
                    state_next = ST_FIX;
                end
                else if (stat.last)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_FIX:
            begin
                state_next = stat.last ? ST_CLAMP : ST_TEST;
            end
            ST_CLAMP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start && command == CMD_MOVE;
                ctrl.wr   = start && command == CMD_WRITE;
            end
            ST_TEST:
            begin
                ctrl.test    = 1'b1;
                ctrl.advance = !stat.overlap;
            end
            ST_FIX:
            begin
                ctrl.fix     = 1'b1;
                ctrl.advance = 1'b1;
            end
            ST_CLAMP:
            begin
                ctrl.clamp = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/amr_datapath.sv */
module amr_datapath
    import amr_pkg::*;
#(
    parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES
)
(
    input  logic                      clk,
    input  ctrl_t                     ctrl,
    output stat_t                     stat,
    input  logic [SLOT_W-1:0]         slot,
    input  logic signed [COORD_W-1:0] box_x,
    input  logic signed [COORD_W-1:0] box_y,
    input  logic [SIZE_W-1:0]         box_w,
    input  logic [SIZE_W-1:0]         box_h,
    input  logic signed [SPEED_W-1:0] speed_x,
    input  logic signed [SPEED_W-1:0] speed_y,
    input  logic [SIZE_W-1:0]         area_width,
    input  logic [SIZE_W-1:0]         area_height,
    input  logic [COUNT_W-1:0]        obstacle_count,
    output logic [SIZE_W-1:0]         new_x,
    output logic [SIZE_W-1:0]         new_y,
    output logic                      any_collision
);

    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CW = $clog2(MAX_OBSTACLES + 1);

    // obstacle table
    rect_t mem [MAX_OBSTACLES];
    rect_t rd_reg;

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_sat;

    pos_t x_reg;
    pos_t y_reg;
    pos_t vx_reg;
    pos_t vy_reg;
    logic [SIZE_W-1:0] w_reg;
    logic [SIZE_W-1:0] h_reg;
    logic hit_reg;

    logic [SIZE_W-1:0] nx_reg;
    logic [SIZE_W-1:0] ny_reg;
    logic coll_reg;

    pos_t ox, oy, ow, oh, bw, bh;
    logic ovx, ovy;
    pos_t snap_x, snap_y;
    pos_t aw, ah, cx, cy;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr && 32'(slot) < MAX_OBSTACLES)
        begin
            mem[AW'(slot)] <= '{x: box_x, y: box_y, w: box_w, h: box_h};
        end
        rd_reg <= mem[idx_next[AW-1:0]];
    end

    // obstacle index walk
    always_comb
    begin
        if (ctrl.load)
        begin
            idx_next = '0;
        end
        else if (ctrl.advance)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    // saturate the count at the table depth
    always_comb
    begin
        if (32'(obstacle_count) > MAX_OBSTACLES)
        begin
            n_sat = CW'(MAX_OBSTACLES);
        end
        else
        begin
            n_sat = CW'(obstacle_count);
        end
    end

    // strict overlap against the current entry
    always_comb
    begin
        ox = sx_coord(rd_reg.x);
        oy = sx_coord(rd_reg.y);
        ow = zx_size(rd_reg.w);
        oh = zx_size(rd_reg.h);
        bw = zx_size(w_reg);
        bh = zx_size(h_reg);
        ovx = (x_reg + bw > ox) && (ox + ow > x_reg);
        ovy = (y_reg + bh > oy) && (oy + oh > y_reg);
        snap_y = (vy_reg > 0) ? oy - bh : oy + oh;
        snap_x = (vx_reg > 0) ? ox - bw : ox + ow;
    end

    assign stat.overlap = ovx && ovy;
    assign stat.last    = (idx_reg + CW'(1)) >= n_reg;
    assign stat.empty   = (obstacle_count == '0);

    // final clamp into the area
    always_comb
    begin
        aw = zx_size(area_width);
        ah = zx_size(area_height);
        cx = (x_reg + bw > aw) ? aw - bw : x_reg;
        cy = (y_reg + bh > ah) ? ah - bh : y_reg;
        if (cx < 0)
        begin
            cx = '0;
        end
        if (cy < 0)
        begin
            cy = '0;
        end
    end

    // box registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctrl.load)
        begin
            x_reg   <= sx_coord(box_x) + sx_speed(speed_x);
            y_reg   <= sx_coord(box_y) + sx_speed(speed_y);
            vx_reg  <= sx_speed(speed_x);
            vy_reg  <= sx_speed(speed_y);
            w_reg   <= box_w;
            h_reg   <= box_h;
            hit_reg <= 1'b0;
            n_reg   <= n_sat;
        end
        else if (ctrl.test && ovx && ovy)
        begin
            // back off on both axes
            x_reg   <= x_reg - vx_reg;
            y_reg   <= y_reg - vy_reg;
            hit_reg <= 1'b1;
        end
        else if (ctrl.fix)
        begin
            if (ovx)
            begin
                // restore x, snap y to the obstacle edge
                x_reg  <= x_reg + vx_reg;
                vy_reg <= snap_y - y_reg;
                y_reg  <= snap_y;
            end
            else if (ovy)
            begin
                // restore y, snap x to the obstacle edge
                y_reg  <= y_reg + vy_reg;
                vx_reg <= snap_x - x_reg;
                x_reg  <= snap_x;
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (ctrl.clamp)
        begin
            nx_reg   <= cx[SIZE_W-1:0];
            ny_reg   <= cy[SIZE_W-1:0];
            coll_reg <= hit_reg;
        end
    end

    assign new_x         = nx_reg;
    assign new_y         = ny_reg;
    assign any_collision = coll_reg;

endmodule

/* rtl/aabb_move_and_resolve.sv */
// Moves a box by its speed and resolves it against up to MAX_OBSTACLES stored
// obstacle rectangles, then clamps it into the area. An item is taken when
// start is high while busy is low. A write item stores an obstacle and gives
// no result. A move item gives one result, shown with done for exactly one
// cycle, after the obstacles have been checked; busy is still high while done
// is shown and falls after it, and the next item is taken in the idle cycle
// after it. The rate of moves is set by the single shared overlap and snap
// unit, which visits one table entry per cycle from the registered-read
// obstacle memory, takes an extra fix step on an entry that overlaps, and is
// followed by a clamp step and a result step.
// The receiver cannot stall: a result must be taken in the cycle that done is
// high. Configuration writes are taken at any time and must only be issued
// while the block is idle.
module aabb_move_and_resolve
    import amr_pkg::*;
#(
    parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      command,
    input  logic [SLOT_W-1:0]         slot,
    input  logic signed [COORD_W-1:0] box_x,
    input  logic signed [COORD_W-1:0] box_y,
    input  logic [SIZE_W-1:0]         box_w,
    input  logic [SIZE_W-1:0]         box_h,
    input  logic signed [SPEED_W-1:0] speed_x,
    input  logic signed [SPEED_W-1:0] speed_y,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                      done,
    output logic [SIZE_W-1:0]         new_x,
    output logic [SIZE_W-1:0]         new_y,
    output logic                      any_collision
);

    logic [SIZE_W-1:0]  area_width_reg;
    logic [SIZE_W-1:0]  area_height_reg;
    logic [COUNT_W-1:0] obst_count_reg;

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // configuration registers, one transfer per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_width_reg  <= RST_AREA_WIDTH;
            area_height_reg <= RST_AREA_HEIGHT;
            obst_count_reg  <= RST_OBST_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AREA_WIDTH:  area_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_AREA_HEIGHT: area_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_OBST_COUNT:  obst_count_reg  <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    amr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done)
    );

    amr_datapath #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_datapath (
        .clk            (clk),
        .ctrl           (ctrl),
        .stat           (stat),
        .slot           (slot),
        .box_x          (box_x),
        .box_y          (box_y),
        .box_w          (box_w),
        .box_h          (box_h),
        .speed_x        (speed_x),
        .speed_y        (speed_y),
        .area_width     (area_width_reg),
        .area_height    (area_height_reg),
        .obstacle_count (obst_count_reg),
        .new_x          (new_x),
        .new_y          (new_y),
        .any_collision  (any_collision)
    );

    // a result strobe lasts one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // a taken move keeps the block busy
    a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_MOVE) |=> busy)
        else $error("move taken but block not busy");

    // a taken write gives no result and leaves the block free
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_WRITE) |=> (!busy && !done))
        else $error("write item disturbed the controller");

    // results only come out while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a move");

endmodule
